// ===== rtl/core/bdll_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded doubly linked list - shared definitions
// Field widths, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdll_pkg;

   localparam int CAPACITY_DEFAULT = 32;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_HEAD = 2'd0,
      MODE_INS_TAIL = 2'd1,
      MODE_DELETE   = 2'd2,
      MODE_DUMP     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic       accept;     // take a request
      logic       setup;      // start a walk at the head
      logic       pop;        // read the free stack, drop its top
      logic       link;       // write value and links of the new node
      logic       ins_fin;    // link the neighbour, move head or tail
      logic       seek;       // read next link of the current node
      logic       walk;       // advance to the next node
      logic       del_read;   // read value and both links of the victim
      logic       del_fin;    // unlink the victim, push it back as free
      logic       dump_read;  // read value and next link at the head
      logic       dump_step;  // advance the dump to the next node
      logic       emit;       // load the response register
      logic       emit_data;  // response carries a list value
      logic       emit_dump;  // last flag follows the end of the list
      status_type emit_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic     req_valid;
      mode_type mode;
      logic     full;
      logic     list_empty;
      logic     pos_bad;
      logic     pos_first;
      logic     walk_last;
      logic     dump_last;
      logic     out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/bdll_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded doubly linked list - channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface bdll_req_if import bdll_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic signed [VALUE_W-1:0] item_value;
   logic [POS_W-1:0]          position;

   modport source (output valid, output mode, output item_value, output position,
                   input ready);
   modport sink   (input valid, input mode, input item_value, input position,
                   output ready);
endinterface

interface bdll_rsp_if import bdll_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] out_value;
   logic [COUNT_W-1:0]        entry_count;
   logic                      valid_res;
   logic                      last;

   modport source (output valid, output status, output out_value, output entry_count,
                   output valid_res, output last, input ready);
   modport sink   (input valid, input status, input out_value, input entry_count,
                   input valid_res, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bdll_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded doubly linked list - generic RAM
// One write port, one read port, registered read data held when not read.
// ----------------------------------------------------------------------------
module bdll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bdll_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded doubly linked list - controller
// Sequences each request through the datapath, one node access a cycle unless the response channel stalls.
// ----------------------------------------------------------------------------
module bdll_ctrl import bdll_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b00000000001,
      ST_DECODE    = 11'b00000000010,
      ST_INS_POP   = 11'b00000000100,
      ST_INS_LINK  = 11'b00000001000,
      ST_INS_FIN   = 11'b00000010000,
      ST_DEL_SEEK  = 11'b00000100000,
      ST_DEL_WALK  = 11'b00001000000,
      ST_DEL_READ  = 11'b00010000000,
      ST_DEL_FIN   = 11'b00100000000,
      ST_DUMP_READ = 11'b01000000000,
      ST_DUMP_EMIT = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      cmd.emit_status = STATUS_OK;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            // hold off requests while reset is applied
            cmd.accept = !reset;
            if (sts.req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.setup = 1'b1;
            case (sts.mode)
               MODE_INS_HEAD, MODE_INS_TAIL: begin
                  if (!sts.full) begin
                     state_in = ST_INS_POP;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = STATUS_FULL;
                     state_in        = ST_IDLE;
                  end
               end
               MODE_DELETE: begin
                  if (!sts.pos_bad) begin
                     state_in = sts.pos_first ? ST_DEL_READ : ST_DEL_SEEK;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = STATUS_RANGE;
                     state_in        = ST_IDLE;
                  end
               end
               MODE_DUMP: begin
                  if (!sts.list_empty) begin
                     state_in = ST_DUMP_READ;
                  end else if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_INS_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            cmd.link = 1'b1;
            state_in = ST_INS_FIN;
         end
         ST_INS_FIN: begin
            if (sts.out_free) begin
               cmd.ins_fin = 1'b1;
               cmd.emit    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_DEL_SEEK: begin
            cmd.seek = 1'b1;
            state_in = ST_DEL_WALK;
         end
         ST_DEL_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DEL_READ;
            end
         end
         ST_DEL_READ: begin
            cmd.del_read = 1'b1;
            state_in     = ST_DEL_FIN;
         end
         ST_DEL_FIN: begin
            if (sts.out_free) begin
               cmd.del_fin   = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_data = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DUMP_READ: begin
            cmd.dump_read = 1'b1;
            state_in      = ST_DUMP_EMIT;
         end
         ST_DUMP_EMIT: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_data = 1'b1;
               cmd.emit_dump = 1'b1;
               if (sts.dump_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dump_step = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bdll_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded doubly linked list - datapath
// Node memories, free stack, list pointers and the response register.
// ----------------------------------------------------------------------------
module bdll_dpath import bdll_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   bdll_req_if.sink     req,
   bdll_rsp_if.source   rsp,
   input  wire cmd_type cmd,
   output sts_type      sts
);

   localparam int IDXW = $clog2(CAPACITY + 1);
   localparam int NW   = $clog2(CAPACITY);
   localparam int WIDE = IDXW + COUNT_W;
   localparam logic [IDXW-1:0] NULL_IDX = IDXW'(CAPACITY);
   localparam logic [IDXW-1:0] LAST_K   = IDXW'(CAPACITY - 1);

   // Request payload
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]          pos_ff, pos_in;

   // Walk state
   logic [IDXW-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic [IDXW-1:0]  k_ff, k_in;

   // List and free stack state
   logic [IDXW-1:0] head_ff, head_in;
   logic [IDXW-1:0] tail_ff, tail_in;
   logic [IDXW-1:0] count_ff, count_in;
   logic [IDXW-1:0] free_top_ff, free_top_in;
   logic [IDXW-1:0] low_ff, low_in;
   logic            fresh_ff, fresh_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_vres_ff, rsp_vres_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Memory ports
   logic [VALUE_W-1:0] val_rd;
   logic [IDXW-1:0]    nxt_rd, prv_rd;
   logic [NW-1:0]      fs_rd;
   logic [NW-1:0]      rd_addr;
   logic               nxt_we, prv_we;
   logic [NW-1:0]      nxt_wa, prv_wa;
   logic [IDXW-1:0]    nxt_wd, prv_wd;

   logic [IDXW-1:0] pop_idx;
   logic [NW-1:0]   node_idx;
   logic            head_null, at_head, nx_ok, pv_ok, out_free;
   logic [IDXW-1:0] nx_norm, pv_norm;
   logic [WIDE-1:0] count_wide, pos_wide, count_out_wide;

   assign pop_idx   = free_top_ff - 1'b1;
   assign node_idx  = fresh_ff ? free_top_ff[NW-1:0] : fs_rd;
   assign head_null = (head_ff == NULL_IDX);
   assign at_head   = (mode_type'(mode_ff) == MODE_INS_HEAD);
   assign nx_ok     = (nxt_rd < NULL_IDX);
   assign pv_ok     = (prv_rd < NULL_IDX);
   assign nx_norm   = nx_ok ? nxt_rd : NULL_IDX;
   assign pv_norm   = pv_ok ? prv_rd : NULL_IDX;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};
   assign pos_wide   = {{IDXW{1'b0}}, pos_ff};
   assign count_out_wide = {{COUNT_W{1'b0}}, count_in};

   assign rd_addr = (cmd.walk || cmd.dump_step) ? nxt_rd[NW-1:0] : cur_ff[NW-1:0];

   always_comb begin
      mode_in     = mode_ff;
      value_in    = value_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      free_top_in = free_top_ff;
      low_in      = low_ff;
      fresh_in    = fresh_ff;

      if (cmd.accept && req.valid) begin
         mode_in  = req.mode;
         value_in = req.item_value;
         pos_in   = req.position;
      end
      if (cmd.setup) begin
         cur_in = head_ff;
         cnt_in = pos_ff - 1'b1;
         k_in   = '0;
      end
      if (cmd.pop) begin
         // entries below the low-water mark were never written and stand for their own index
         free_top_in = pop_idx;
         fresh_in    = (pop_idx < low_ff);
         low_in      = (pop_idx < low_ff) ? pop_idx : low_ff;
      end
      if (cmd.link) begin
         cur_in = IDXW'(node_idx);
      end
      if (cmd.ins_fin) begin
         if (head_null) begin
            head_in = cur_ff;
            tail_in = cur_ff;
         end else if (at_head) begin
            head_in = cur_ff;
         end else begin
            tail_in = cur_ff;
         end
         count_in = count_ff + 1'b1;
      end
      if (cmd.walk) begin
         cur_in = nxt_rd;
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.del_fin) begin
         if (!pv_ok) begin
            head_in = nx_norm;
         end
         if (!nx_ok) begin
            tail_in = pv_norm;
         end
         free_top_in = free_top_ff + 1'b1;
         count_in    = count_ff - 1'b1;
      end
      if (cmd.dump_step) begin
         cur_in = nxt_rd;
         k_in   = k_ff + 1'b1;
      end
   end

   // Next-link write port: new node, old tail, or predecessor of a victim
   always_comb begin
      nxt_we = 1'b0;
      nxt_wa = node_idx;
      nxt_wd = (head_null || !at_head) ? NULL_IDX : head_ff;
      if (cmd.link) begin
         nxt_we = 1'b1;
      end else if (cmd.ins_fin && !head_null && !at_head) begin
         nxt_we = 1'b1;
         nxt_wa = tail_ff[NW-1:0];
         nxt_wd = cur_ff;
      end else if (cmd.del_fin && pv_ok) begin
         nxt_we = 1'b1;
         nxt_wa = prv_rd[NW-1:0];
         nxt_wd = nx_norm;
      end
   end

   // Previous-link write port: new node, old head, or successor of a victim
   always_comb begin
      prv_we = 1'b0;
      prv_wa = node_idx;
      prv_wd = (head_null || at_head) ? NULL_IDX : tail_ff;
      if (cmd.link) begin
         prv_we = 1'b1;
      end else if (cmd.ins_fin && !head_null && at_head) begin
         prv_we = 1'b1;
         prv_wa = head_ff[NW-1:0];
         prv_wd = cur_ff;
      end else if (cmd.del_fin && nx_ok) begin
         prv_we = 1'b1;
         prv_wa = nxt_rd[NW-1:0];
         prv_wd = pv_norm;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_vres_in   = rsp_vres_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.emit_status;
         rsp_value_in  = cmd.emit_data ? val_rd : '0;
         rsp_count_in  = count_out_wide[COUNT_W-1:0];
         rsp_vres_in   = cmd.emit_data;
         rsp_last_in   = cmd.emit_dump ? sts.dump_last : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NULL_IDX;
         tail_ff      <= NULL_IDX;
         count_ff     <= '0;
         free_top_ff  <= NULL_IDX;
         low_ff       <= NULL_IDX;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      fresh_ff      <= fresh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_vres_ff   <= rsp_vres_in;
      rsp_last_ff   <= rsp_last_in;
   end

   bdll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_values (
      .clock   (clock),
      .wr_en   (cmd.link),
      .wr_addr (node_idx),
      .wr_data (value_ff),
      .rd_en   (cmd.del_read || cmd.dump_read || cmd.dump_step),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   bdll_ram #(.WIDTH(IDXW), .DEPTH(CAPACITY)) u_next (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_en   (cmd.seek || cmd.walk || cmd.del_read || cmd.dump_read || cmd.dump_step),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd)
   );

   bdll_ram #(.WIDTH(IDXW), .DEPTH(CAPACITY)) u_prev (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_en   (cmd.del_read),
      .rd_addr (rd_addr),
      .rd_data (prv_rd)
   );

   bdll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_free (
      .clock   (clock),
      .wr_en   (cmd.del_fin),
      .wr_addr (free_top_ff[NW-1:0]),
      .wr_data (cur_ff[NW-1:0]),
      .rd_en   (cmd.pop),
      .rd_addr (pop_idx[NW-1:0]),
      .rd_data (fs_rd)
   );

   assign req.ready = cmd.accept;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.out_value   = rsp_value_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.valid_res   = rsp_vres_ff;
   assign rsp.last        = rsp_last_ff;

   assign sts.req_valid  = req.valid;
   assign sts.mode       = mode_type'(mode_ff);
   assign sts.full       = (free_top_ff == '0);
   assign sts.list_empty = head_null || (count_ff == '0);
   assign sts.pos_bad    = (pos_ff == '0) || (pos_wide > count_wide) || head_null;
   assign sts.pos_first  = (pos_ff == POS_W'(1));
   assign sts.walk_last  = (cnt_ff == POS_W'(1));
   assign sts.dump_last  = !nx_ok || (k_ff >= LAST_K);
   assign sts.out_free   = out_free;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_doubly_linked_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded doubly linked list - top level
// List of signed 32-bit values in node memories, with a free stack.
// ----------------------------------------------------------------------------
// A list of up to CAPACITY signed values kept in three node memories (value,
// next link, previous link) with a stack of free node indices. Each request
// is one operation: insert at head, insert at tail, delete at a 1-based
// position from the head, or dump the whole list head to tail. One request
// is handled at a time. An insert pops a free index, writes the new node and
// then links its neighbour and moves the head or tail as its response is
// loaded; a delete at position p follows the next links one node a cycle
// through the next-link memory's registered read port, then reads the victim
// and unlinks it; a dump reads the head and then gives one response a cycle
// while the response channel keeps up. A stalled response channel holds
// the block in its final state until the response register frees. The
// next request is taken in the cycle after the last response of the
// previous one has been loaded into the response register, so a waiting
// response does not hold the request side. No clearing pass is needed
// after reset: the free stack's untouched entries are recognised by a
// low-water mark and read as their own index.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list import bdll_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bdll_req_if.sink   req_if,
   bdll_rsp_if.source rsp_if
);

   cmd_type cmd;
   sts_type sts;

   // Controller: walks each request through its states and issues commands
   bdll_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Datapath: node memories, free stack, head/tail/count and response register
   bdll_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule
`default_nettype wire

// ===== tb/list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linked list checker
// Watches the request and response channels, keeps its own copy of the list
// and free stack, works out the responses of every accepted request and
// compares each accepted response with the oldest one still due.
// ----------------------------------------------------------------------------
module list_checker import bdll_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [VALUE_W-1:0]   req_item_value,
   input  wire logic [POS_W-1:0]     req_position,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [STATUS_W-1:0]  rsp_status,
   input  wire logic [VALUE_W-1:0]   rsp_out_value,
   input  wire logic [COUNT_W-1:0]   rsp_entry_count,
   input  wire logic                 rsp_valid_res,
   input  wire logic                 rsp_last,
   output int                        fail_count,
   output int                        outstanding
);

   localparam int CAP = CAPACITY_DEFAULT;
   localparam int NIL = CAP;

   typedef logic [COUNT_W-1:0] link_type;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        count;
      logic                      valid_res;
      logic                      last;
   } list_result_type;

   logic signed [VALUE_W-1:0] node_value [CAP];
   link_type                  next_link  [CAP];
   link_type                  prev_link  [CAP];
   link_type                  free_stack [CAP];
   link_type                  free_top;
   link_type                  head_idx;
   link_type                  tail_idx;
   logic [COUNT_W-1:0]        list_len;

   list_result_type results_due [$];
   list_result_type want;
   int              results_seen;

   initial begin
      fail_count   = 0;
      outstanding  = 0;
      results_seen = 0;
   end

   task automatic report_mismatch(string msg);
      $display("%0t: response %0d: %s", $time, results_seen, msg);
      fail_count++;
   endtask

   function automatic void queue_result(status_type st, logic signed [VALUE_W-1:0] v,
                                        logic vr, logic lst);
      list_result_type r;
      r.status    = st;
      r.value     = v;
      r.count     = list_len;
      r.valid_res = vr;
      r.last      = lst;
      results_due.push_back(r);
   endfunction

   // Update the list copy for one request and queue the responses it causes
   function automatic void apply_request(mode_type mode, logic signed [VALUE_W-1:0] value,
                                         logic [POS_W-1:0] pos);
      int cur;
      int nx;
      int pv;
      int k;
      case (mode)
         MODE_INS_HEAD, MODE_INS_TAIL: begin
            if (free_top == 0) begin
               queue_result(STATUS_FULL, '0, 1'b0, 1'b1);
            end else begin
               free_top = free_top - 1'b1;
               cur = free_stack[free_top];
               node_value[cur] = value;
               if (head_idx == NIL) begin
                  next_link[cur] = link_type'(NIL);
                  prev_link[cur] = link_type'(NIL);
                  head_idx = link_type'(cur);
                  tail_idx = link_type'(cur);
               end else if (mode == MODE_INS_HEAD) begin
                  next_link[cur] = head_idx;
                  prev_link[cur] = link_type'(NIL);
                  prev_link[head_idx] = link_type'(cur);
                  head_idx = link_type'(cur);
               end else begin
                  next_link[cur] = link_type'(NIL);
                  prev_link[cur] = tail_idx;
                  next_link[tail_idx] = link_type'(cur);
                  tail_idx = link_type'(cur);
               end
               list_len = list_len + 1'b1;
               queue_result(STATUS_OK, '0, 1'b0, 1'b1);
            end
         end
         MODE_DELETE: begin
            if (pos == 0 || pos > list_len || head_idx == NIL) begin
               queue_result(STATUS_RANGE, '0, 1'b0, 1'b1);
            end else begin
               cur = head_idx;
               for (k = 1; k < pos; k++) begin
                  if (next_link[cur] == NIL) break;
                  cur = next_link[cur];
               end
               nx = next_link[cur];
               pv = prev_link[cur];
               if (pv != NIL) next_link[pv] = link_type'(nx);
               else head_idx = link_type'(nx);
               if (nx != NIL) prev_link[nx] = link_type'(pv);
               else tail_idx = link_type'(pv);
               if (free_top < CAP) begin
                  free_stack[free_top] = link_type'(cur);
                  free_top = free_top + 1'b1;
               end
               list_len = list_len - 1'b1;
               queue_result(STATUS_OK, node_value[cur], 1'b1, 1'b1);
            end
         end
         default: begin
            if (head_idx == NIL || list_len == 0) begin
               queue_result(STATUS_OK, '0, 1'b0, 1'b1);
            end else begin
               cur = head_idx;
               k = 0;
               while (cur != NIL && k < CAP) begin
                  nx = next_link[cur];
                  queue_result(STATUS_OK, node_value[cur], 1'b1, (nx == NIL) || (k + 1 >= CAP));
                  k++;
                  cur = nx;
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAP; i++) begin
            free_stack[i] = link_type'(i);
         end
         free_top = link_type'(CAP);
         head_idx = link_type'(NIL);
         tail_idx = link_type'(NIL);
         list_len = '0;
         results_due.delete();
      end else begin
         // Take the request first so a same-edge response would still find it
         if (req_valid && req_ready) begin
            apply_request(mode_type'(req_mode), req_item_value, req_position);
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("response with nothing outstanding");
            end else begin
               want = results_due.pop_front();
               if (rsp_status != want.status)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
               if ($signed(rsp_out_value) != want.value)
                  report_mismatch($sformatf("out_value got %0d want %0d",
                                            $signed(rsp_out_value), want.value));
               if (rsp_entry_count != want.count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_entry_count, want.count));
               if (rsp_valid_res != want.valid_res)
                  report_mismatch($sformatf("valid_res got %0b want %0b",
                                            rsp_valid_res, want.valid_res));
               if (rsp_last != want.last)
                  report_mismatch($sformatf("last got %0b want %0b", rsp_last, want.last));
            end
            results_seen++;
         end
      end
      outstanding <= results_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linked list testbench
// Drives directed and random list operations into the block in bursts, stalls
// the response side, and lets the checker judge every response.
// ----------------------------------------------------------------------------
module testbench;
   import bdll_pkg::*;

   localparam int CAP          = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 246;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 2 * CAP + 16;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AFTER   = 80;

   logic clock;
   logic reset;

   bdll_req_if req_bus ();
   bdll_rsp_if rsp_bus ();

   int fail_count;
   int outstanding;

   // Stimulus bookkeeping: entries the list should hold, left in the burst
   int stim_len;
   int burst_left;

   // Response side bookkeeping, owned by the receiver process
   int responses_taken;
   int hold_left;
   int stall_left;
   int window;
   bit long_hold_done;

   int cycle_count;

   bounded_doubly_linked_list dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   list_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .req_mode        (req_bus.mode),
      .req_item_value  (req_bus.item_value),
      .req_position    (req_bus.position),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_status      (rsp_bus.status),
      .rsp_out_value   (rsp_bus.out_value),
      .rsp_entry_count (rsp_bus.entry_count),
      .rsp_valid_res   (rsp_bus.valid_res),
      .rsp_last        (rsp_bus.last),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs or loses a response
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: alternate windows of full speed and short random stalls, and
   // once, after enough responses, hold ready low for a long stretch so the
   // block backs up and refuses further requests.
   initial begin
      responses_taken = 0;
      hold_left       = 0;
      stall_left      = 0;
      window          = 0;
      long_hold_done  = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) responses_taken++;
      if (!long_hold_done && responses_taken >= HOLD_AFTER) begin
         hold_left      = LONG_HOLD;
         long_hold_done = 1'b1;
      end
      window++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (window[7] && $urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic int pick_burst();
      // Mostly short bursts, now and then a long run with no idling
      return ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
   endfunction

   // Offer one request, hold it until taken, then idle if the burst is over
   task automatic send_request(mode_type op, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= op;
      req_bus.item_value <= value;
      req_bus.position   <= pos;
      do @(posedge clock); while (!req_bus.ready);
      case (op)
         MODE_INS_HEAD, MODE_INS_TAIL: if (stim_len < CAP) stim_len++;
         MODE_DELETE: if (pos >= 1 && pos <= stim_len) stim_len--;
         default: ;
      endcase
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = pick_burst();
      end
   endtask

   // Drop valid and hold until every due response has been taken
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int       n;
      int       phase;
      int       roll;
      int       ins_pct;
      int       del_pct;
      mode_type op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_INS_HEAD;
      req_bus.item_value = '0;
      req_bus.position   = '0;
      stim_len           = 0;
      burst_left         = pick_burst();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: empty list, range errors, value extremes, and unlinking the
      // head, the tail, a middle node and the only node
      send_request(MODE_DUMP,     '0, '0);
      send_request(MODE_DELETE,   '0, 6'd0);
      send_request(MODE_DELETE,   '0, 6'd1);
      send_request(MODE_INS_HEAD, 32'h7FFF_FFFF, '0);
      send_request(MODE_INS_TAIL, 32'h8000_0000, '0);
      send_request(MODE_INS_HEAD, 32'h0000_0000, '0);
      send_request(MODE_INS_TAIL, 32'hFFFF_FFFF, '0);
      send_request(MODE_DUMP,     '0, '0);
      send_request(MODE_DELETE,   '0, 6'd0);
      send_request(MODE_DELETE,   '0, 6'd5);
      send_request(MODE_DELETE,   '0, 6'd63);
      send_request(MODE_DELETE,   '0, 6'd4);
      send_request(MODE_DELETE,   '0, 6'd1);
      send_request(MODE_INS_TAIL, 32'h5555_5555, '0);
      send_request(MODE_DELETE,   '0, 6'd2);
      send_request(MODE_INS_HEAD, 32'hAAAA_AAAA, '0);
      send_request(MODE_DUMP,     '0, '0);
      send_request(MODE_DELETE,   '0, 6'd3);
      send_request(MODE_DELETE,   '0, 6'd1);
      send_request(MODE_DELETE,   '0, 6'd1);
      send_request(MODE_DUMP,     '0, '0);
      send_request(MODE_INS_TAIL, 32'h0000_0001, '0);
      send_request(MODE_DELETE,   '0, 6'd2);
      send_request(MODE_DELETE,   '0, 6'd1);
      wait_drained();

      // Random: cycle through growing, mixed and shrinking phases so the list
      // fills to capacity, refuses inserts, and drains back to empty
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         phase = (n / 40) % 4;
         case (phase)
            0:       begin ins_pct = 80; del_pct = 10; end
            2:       begin ins_pct = 10; del_pct = 80; end
            default: begin ins_pct = 40; del_pct = 40; end
         endcase
         if (n == RANDOM_ITEMS / 2) wait_drained();

         roll = $urandom_range(0, 99);
         if (roll < ins_pct)
            op = $urandom_range(0, 1) ? MODE_INS_TAIL : MODE_INS_HEAD;
         else if (roll < ins_pct + del_pct)
            op = MODE_DELETE;
         else
            op = MODE_DUMP;

         case ($urandom_range(0, 9))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            default: value = $urandom;
         endcase

         // Mostly positions inside the list, the rest anywhere in the field
         if (stim_len > 0 && $urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(1, stim_len));
         else
            pos = POS_W'($urandom_range(0, 63));

         send_request(op, value, pos);
      end

      // Let everything drain, then allow for a walk still in flight
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
